// ===== src/srr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and constants for the sentence receive ring.
// ----------------------------------------------------------------------------
package srr_pkg;

	localparam int RING_DEPTH_DEF = 32;

	localparam logic [7:0] START_MARK = 8'h24;   // '$'
	localparam logic [7:0] LINE_END   = 8'h0A;   // '\n'

	localparam logic [5:0] BACKLOG_RESET = 6'd29;

	// command codes carried in the input tuser
	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POLL = 2'd1;
	localparam logic [1:0] CMD_POP  = 2'd2;

	// configuration register indexes
	localparam logic REG_ENABLE  = 1'b0;
	localparam logic REG_BACKLOG = 1'b1;

	typedef struct packed {
		logic       enable;
		logic [5:0] backlog_limit;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_POP,
		ST_DONE
	} st_t;

endpackage

// ===== src/srr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/srr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_ctrl
// Command sequencer: ring pointers, sentence flag, start-marker scan and
// the result register.
// ----------------------------------------------------------------------------
module srr_ctrl
	import srr_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	localparam int PW = $clog2(RING_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    in_cmd,
	input  logic [7:0]    in_byte,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          out_receiving,
	output logic [7:0]    out_pop_data,
	output logic          out_pop_valid,
	output logic          out_dropped,
	output logic          ram_we,
	output logic [PW-1:0] ram_waddr,
	output logic [7:0]    ram_wdata,
	output logic [PW-1:0] ram_raddr,
	input  logic [7:0]    ram_rdata
);

	localparam int CW = (PW + 1 > 6) ? PW + 1 : 6;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		return (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	st_t state_q, state_d;

	logic [PW-1:0] rp_q, wp_q;
	logic          insent_q;
	logic [1:0]    cmd_q;
	logic [7:0]    byte_q;
	logic          dropped_q;
	logic [7:0]    pop_data_q;
	logic          pop_valid_q;
	logic          m_valid_q;
	logic          m_receiving_q;
	logic [7:0]    m_pop_data_q;
	logic          m_pop_valid_q;
	logic          m_dropped_q;

	logic [PW-1:0] rp_next, wp_next;
	logic          full, empty, is_mark, out_free, below_limit;
	logic [CW-1:0] count;

	assign rp_next  = ring_next(rp_q);
	assign wp_next  = ring_next(wp_q);
	assign full     = (wp_next == rp_q);
	assign empty    = (rp_q == wp_q);
	assign is_mark  = (ram_rdata == START_MARK);
	assign out_free = !m_valid_q || out_ready;

	always_comb begin
		if (wp_q >= rp_q) begin
			count = CW'(wp_q) - CW'(rp_q);
		end else begin
			count = CW'(wp_q) + CW'(RING_DEPTH) - CW'(rp_q);
		end
	end

	assign below_limit = (count < CW'(cfg.backlog_limit));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (cmd_q)
					CMD_POLL: begin
						state_d = (cfg.enable && !insent_q && !empty) ? ST_SCAN : ST_DONE;
					end
					CMD_POP: begin
						state_d = empty ? ST_DONE : ST_POP;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_SCAN: begin
				if (is_mark || rp_next == wp_q) state_d = ST_DONE;
			end
			ST_POP: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		ram_we    = (state_q == ST_EXEC) && (cmd_q == CMD_PUSH) && !full;
		ram_waddr = wp_q;
		ram_wdata = byte_q;
		// during the scan the next entry is fetched while the current one is checked
		ram_raddr = (state_q == ST_SCAN) ? rp_next : rp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q      <= '0;
			wp_q      <= '0;
			insent_q  <= 1'b0;
			cmd_q     <= CMD_PUSH;
			m_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) cmd_q <= in_cmd;
				end
				ST_EXEC: begin
					if (cmd_q == CMD_PUSH && !full) wp_q <= wp_next;
					if (cmd_q == CMD_POLL && !cfg.enable) insent_q <= 1'b0;
				end
				ST_SCAN: begin
					if (is_mark) begin
						insent_q <= below_limit;
					end else begin
						rp_q <= rp_next;
					end
				end
				ST_POP: begin
					rp_q     <= rp_next;
					insent_q <= (ram_rdata != LINE_END);
				end
				default: ;
			endcase

			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					byte_q      <= in_byte;
					dropped_q   <= 1'b0;
					pop_data_q  <= '0;
					pop_valid_q <= 1'b0;
				end
			end
			ST_EXEC: begin
				if (cmd_q == CMD_PUSH && full) dropped_q <= 1'b1;
			end
			ST_POP: begin
				pop_data_q  <= ram_rdata;
				pop_valid_q <= 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					m_receiving_q <= insent_q;
					m_pop_data_q  <= pop_data_q;
					m_pop_valid_q <= pop_valid_q;
					m_dropped_q   <= dropped_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = m_valid_q;
	assign out_receiving = m_receiving_q;
	assign out_pop_data  = m_pop_data_q;
	assign out_pop_valid = m_pop_valid_q;
	assign out_dropped   = m_dropped_q;

endmodule

// ===== src/sentence_receive_ring_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sentence_receive_ring_core
// Byte receive ring with start-of-sentence synchronisation.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          contents
//  s_*       in         s_tvalid/s_tready  tdata: rx_byte; tuser: cmd
//  m_*       out        m_tvalid/m_tready  tdata: receiving, pop_data, dropped;
//                                          tuser: pop_valid
//  cfg_*     in         cfg_valid/ready    cfg_index, cfg_data
//
//  One item is handled at a time: idle, execute, done; a pop of a stored byte
//  adds the pop state, a poll may add the scan state over up to RING_DEPTH - 1
//  entries, one ring RAM read a cycle. Reset clears pointers, sentence flag and
//  enable and sets the backlog limit to BACKLOG_RESET; the ring RAM is not
//  cleared. A held result delays only the next acceptance, not the work.
// ----------------------------------------------------------------------------
module sentence_receive_ring_core
	import srr_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] receiving, [8:1] pop_data, [9] dropped
	output logic        m_tuser,   // [0] pop_valid
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data
);

	localparam int PW = $clog2(RING_DEPTH);

	cfg_t cfg_q;

	logic          ram_we;
	logic [PW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;
	logic          receiving, pop_valid, dropped;
	logic [7:0]    pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable        <= 1'b0;
			cfg_q.backlog_limit <= BACKLOG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ENABLE:  cfg_q.enable        <= cfg_data[0];
				REG_BACKLOG: cfg_q.backlog_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	srr_ctrl #(
		.RING_DEPTH(RING_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_cmd       (s_tuser),
		.in_byte      (s_tdata),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_receiving(receiving),
		.out_pop_data (pop_data),
		.out_pop_valid(pop_valid),
		.out_dropped  (dropped),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	srr_ram #(
		.WIDTH(8),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign m_tdata = {6'b0, dropped, pop_data, receiving};
	assign m_tuser = pop_valid;

endmodule

// ===== src/srr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_checker
// Port-level checks on the result stream of the sentence receive ring.
// ----------------------------------------------------------------------------
module srr_checker
	import srr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a pop and a drop never come from the same item
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser && m_tdata[9]))
		else $error("pop_valid and dropped both set");

	// no byte removed means no data shown
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[8:1] == 8'h00)
		else $error("pop_data non-zero without pop_valid");

	// a popped newline ends the sentence, any other byte keeps it open
	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[0] == (m_tdata[8:1] != LINE_END))
		else $error("receiving flag wrong after pop");

endmodule

bind sentence_receive_ring_core srr_checker u_srr_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sentence receive ring. A table of directed
// commands (reset state, byte extremes, marker search, limit corner values)
// is followed by random phases built from sentences, noise, ring fills and
// drains. Results are checked against an in-bench model or a typed row.
// ----------------------------------------------------------------------------
module tb_top;
	import srr_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1800;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS = 30;
	localparam int DIR_ROWS = 31;

	typedef struct packed {
		logic       receiving;
		logic [7:0] pop_data;
		logic       pop_valid;
		logic       dropped;
	} ring_result_t;

	typedef enum logic [1:0] {ROW_ITEM, ROW_CFG_EN, ROW_CFG_LIM} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		logic [1:0]   cmd;
		logic [7:0]   val;
		logic         typed;
		ring_result_t res;
	} dir_row_t;

	localparam ring_result_t QUIET = '0;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [5:0]  cfg_data;

	// model of the ring, advanced on every input transfer
	logic [7:0] ring_mem [RING_DEPTH_DEF];
	logic [4:0] rd_ptr;
	logic [4:0] wr_ptr;
	logic       in_sentence;
	logic       cfg_en;
	logic [5:0] cfg_limit;

	ring_result_t expected_results [$];
	ring_result_t typed_res;
	bit           use_typed;
	bit           tx_idle;
	bit           rx_idle;
	bit           hold_req;
	int           fails;
	int           random_items;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_ITEM,    CMD_POP,    8'h00,      1'b1, QUIET},      // pop of an empty ring
		'{ROW_ITEM,    CMD_POLL,   8'h00,      1'b1, QUIET},      // poll while disabled
		'{ROW_ITEM,    CMD_UNUSED, 8'hFF,      1'b1, QUIET},
		'{ROW_ITEM,    CMD_PUSH,   8'h00,      1'b1, QUIET},
		'{ROW_ITEM,    CMD_PUSH,   8'hFF,      1'b1, QUIET},
		'{ROW_ITEM,    CMD_POP,    8'h00,      1'b1, '{1'b1, 8'h00, 1'b1, 1'b0}},
		'{ROW_ITEM,    CMD_POP,    8'h00,      1'b1, '{1'b1, 8'hFF, 1'b1, 1'b0}},
		'{ROW_ITEM,    CMD_POLL,   8'h00,      1'b1, QUIET},      // disabled poll clears flag
		'{ROW_CFG_EN,  CMD_PUSH,   8'h01,      1'b0, QUIET},
		'{ROW_ITEM,    CMD_PUSH,   8'h41,      1'b0, QUIET},
		'{ROW_ITEM,    CMD_PUSH,   START_MARK, 1'b0, QUIET},
		'{ROW_ITEM,    CMD_PUSH,   8'h42,      1'b0, QUIET},
		'{ROW_ITEM,    CMD_PUSH,   LINE_END,   1'b0, QUIET},
		'{ROW_ITEM,    CMD_POLL,   8'h00,      1'b0, QUIET},      // skips up to the marker
		'{ROW_ITEM,    CMD_POP,    8'h00,      1'b0, QUIET},
		'{ROW_ITEM,    CMD_POP,    8'h00,      1'b0, QUIET},
		'{ROW_ITEM,    CMD_POP,    8'h00,      1'b0, QUIET},      // newline ends the sentence
		'{ROW_ITEM,    CMD_PUSH,   8'h78,      1'b0, QUIET},
		'{ROW_ITEM,    CMD_POLL,   8'h00,      1'b0, QUIET},      // no marker: ring emptied
		'{ROW_ITEM,    CMD_POP,    8'h00,      1'b1, QUIET},
		'{ROW_ITEM,    CMD_POLL,   8'h00,      1'b1, QUIET},      // enabled, ring empty
		'{ROW_CFG_LIM, CMD_PUSH,   8'h00,      1'b0, QUIET},
		'{ROW_ITEM,    CMD_PUSH,   START_MARK, 1'b0, QUIET},
		'{ROW_ITEM,    CMD_POLL,   8'h00,      1'b1, QUIET},      // zero limit never enters
		'{ROW_CFG_LIM, CMD_PUSH,   8'h3F,      1'b0, QUIET},
		'{ROW_ITEM,    CMD_POLL,   8'h00,      1'b0, QUIET},
		'{ROW_ITEM,    CMD_POLL,   8'h00,      1'b0, QUIET},      // already inside: no change
		'{ROW_ITEM,    CMD_UNUSED, 8'h00,      1'b0, QUIET},
		'{ROW_ITEM,    CMD_POP,    8'h00,      1'b0, QUIET},
		'{ROW_CFG_EN,  CMD_PUSH,   8'h00,      1'b0, QUIET},
		'{ROW_ITEM,    CMD_POLL,   8'h00,      1'b1, QUIET}
	};

	sentence_receive_ring_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic ring_result_t predict_ring(logic [1:0] cmd, logic [7:0] rx_byte);
		ring_result_t r;
		logic [7:0]   v;
		logic [4:0]   queued;
		r = '0;
		case (cmd)
			CMD_PUSH: begin
				if (wr_ptr + 5'd1 == rd_ptr) begin
					r.dropped = 1'b1;
				end else begin
					ring_mem[wr_ptr] = rx_byte;
					wr_ptr = wr_ptr + 5'd1;
				end
			end
			CMD_POLL: begin
				if (!cfg_en) begin
					in_sentence = 1'b0;
				end else if (!in_sentence && rd_ptr != wr_ptr) begin
					while (rd_ptr != wr_ptr && ring_mem[rd_ptr] != START_MARK)
						rd_ptr = rd_ptr + 5'd1;
					if (rd_ptr != wr_ptr) begin
						queued = wr_ptr - rd_ptr;
						in_sentence = ({1'b0, queued} < cfg_limit);
					end
				end
			end
			CMD_POP: begin
				if (rd_ptr != wr_ptr) begin
					v = ring_mem[rd_ptr];
					rd_ptr = rd_ptr + 5'd1;
					r.pop_data = v;
					r.pop_valid = 1'b1;
					in_sentence = (v != LINE_END);
				end
			end
			default: ;
		endcase
		r.receiving = in_sentence;
		return r;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] text_byte();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			return START_MARK;
		if (pick == 2)
			return LINE_END;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [5:0] pick_limit();
		case ($urandom_range(0, 7))
			0: return 6'd0;
			1: return 6'd1;
			2: return 6'd2;
			3: return 6'd31;
			4: return 6'd32;
			5: return 6'd63;
			default: return 6'($urandom_range(0, 63));
		endcase
	endfunction

	// predictor, scoreboard and config shadow, all on the rising edge
	always @(posedge clk) begin
		ring_result_t calc;
		ring_result_t want;
		ring_result_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ENABLE)
					cfg_en = cfg_data[0];
				else
					cfg_limit = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				calc = predict_ring(s_tuser, s_tdata);
				expected_results.push_back(use_typed ? typed_res : calc);
			end
			if (m_tvalid && m_tready) begin
				got = {m_tdata[0], m_tdata[8:1], m_tuser, m_tdata[9]};
				if (expected_results.size() == 0) begin
					if (fails < MAX_REPORTS)
						$display("%0t: result with nothing expected, got %h", $time, got);
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (got.receiving !== want.receiving) begin
						if (fails < MAX_REPORTS)
							$display("%0t: receiving expected %0b got %0b", $time,
								want.receiving, got.receiving);
						fails++;
					end
					if (got.pop_data !== want.pop_data) begin
						if (fails < MAX_REPORTS)
							$display("%0t: pop_data expected %h got %h", $time,
								want.pop_data, got.pop_data);
						fails++;
					end
					if (got.pop_valid !== want.pop_valid) begin
						if (fails < MAX_REPORTS)
							$display("%0t: pop_valid expected %0b got %0b", $time,
								want.pop_valid, got.pop_valid);
						fails++;
					end
					if (got.dropped !== want.dropped) begin
						if (fails < MAX_REPORTS)
							$display("%0t: dropped expected %0b got %0b", $time,
								want.dropped, got.dropped);
						fails++;
					end
				end
			end
		end
	end

	// result side: random back-pressure plus one long hold on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (rx_idle && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat (gap_len()) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top failed");
		$finish;
	end

	task automatic send_item(input logic [1:0] cmd, input logic [7:0] rx_byte,
		input bit typed = 1'b0, input ring_result_t res = QUIET);
		int gap;
		gap = (tx_idle && $urandom_range(0, 9) < 4) ? gap_len() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		use_typed = typed;
		typed_res = res;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= rx_byte;
		do @(posedge clk); while (!s_tready);
		if (cmd != CMD_UNUSED)
			random_items++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [5:0] val);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sentence();
		int len;
		repeat ($urandom_range(0, 3)) send_item(CMD_PUSH, 8'($urandom_range(0, 255)));
		send_item(CMD_PUSH, START_MARK);
		len = $urandom_range(0, 12);
		repeat (len) send_item(CMD_PUSH, text_byte());
		if ($urandom_range(0, 9) != 0)
			send_item(CMD_PUSH, LINE_END);
		repeat ($urandom_range(1, 2)) send_item(CMD_POLL, 8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, len + 4)) send_item(CMD_POP, 8'($urandom_range(0, 255)));
	endtask

	// fills past capacity so that pushes get dropped, then searches and drains
	task automatic send_fill();
		int mark_at;
		mark_at = $urandom_range(0, 33);
		for (int i = 0; i < 34; i++)
			send_item(CMD_PUSH, (i == mark_at) ? START_MARK : text_byte());
		send_item(CMD_POLL, 8'h00);
		repeat ($urandom_range(0, 34)) send_item(CMD_POP, 8'h00);
	endtask

	initial begin
		int phase;
		int phase_end;
		int pick;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_PUSH;
		cfg_valid = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data = '0;
		use_typed = 1'b0;
		typed_res = QUIET;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_req = 1'b0;
		fails = 0;
		rd_ptr = '0;
		wr_ptr = '0;
		in_sentence = 1'b0;
		cfg_en = 1'b0;
		cfg_limit = BACKLOG_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_CFG_EN:  write_reg(REG_ENABLE, dir_rows[i].val[5:0]);
				ROW_CFG_LIM: write_reg(REG_BACKLOG, dir_rows[i].val[5:0]);
				default: send_item(dir_rows[i].cmd, dir_rows[i].val, dir_rows[i].typed,
					dir_rows[i].res);
			endcase
		end

		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			write_reg(REG_ENABLE, {5'd0, 1'($urandom_range(0, 4) != 0)});
			write_reg(REG_BACKLOG, pick_limit());
			tx_idle = ($urandom_range(0, 2) != 0);
			rx_idle = ($urandom_range(0, 2) != 0);
			if (phase == 2)
				hold_req = 1'b1;
			phase_end = random_items + $urandom_range(60, 160);
			if (phase == 0)
				send_fill();
			while (random_items < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					send_sentence();
				else if (pick < 80)
					send_item(2'($urandom_range(0, 3)), text_byte());
				else if (pick < 88)
					send_fill();
				else
					repeat ($urandom_range(1, 33)) send_item(CMD_POP, 8'h00);
			end
			phase++;
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ===== sentence_receive_ring_core.f =====
src/srr_pkg.sv
src/srr_ram.sv
src/srr_ctrl.sv
src/sentence_receive_ring_core.sv
src/srr_checker.sv
verif/tb_top.sv
